// ===== rtl/core/utt_pkg.sv =====
`timescale 1ns / 1ps
package utt_pkg;

  localparam int UTT_QUEUE_DEPTH = 4;

  localparam logic [15:0] UTT_REPL_CHAR   = 16'hFFFD;
  localparam logic [5:0]  UTT_SURR_HIGH   = 6'h36;
  localparam logic [5:0]  UTT_SURR_LOW    = 6'h37;
  localparam logic [20:0] UTT_SUPP_OFFSET = 21'h10000;

  localparam logic [2:0] UTT_LEN_NONE = 3'd0;
  localparam logic [2:0] UTT_LEN_ONE  = 3'd1;
  localparam logic [2:0] UTT_LEN_TWO  = 3'd2;
  localparam logic [2:0] UTT_LEN_FOUR = 3'd4;
  localparam logic [2:0] UTT_LEN_THREE = 3'd3;

  // One job: up to two code points and the end-of-stream mark.
  // len_a of zero with last set is the empty end marker.
  typedef struct packed {
    logic [20:0] cp_a;
    logic [2:0]  len_a;
    logic [15:0] cp_b;
    logic [2:0]  len_b;
    logic        last;
  } utt_job_t;

  function automatic logic [2:0] utt_word_len(input logic [15:0] word);
    logic [2:0] len;
    begin
      if (word[15:7] == 9'd0) begin
        len = UTT_LEN_ONE;
      end else if (word[15:11] == 5'd0) begin
        len = UTT_LEN_TWO;
      end else begin
        len = UTT_LEN_THREE;
      end
      return len;
    end
  endfunction

  function automatic logic [7:0] utt_enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                              input logic [1:0] idx);
    logic [7:0] b;
    begin
      b = 8'h00;
      unique case (len)
        UTT_LEN_ONE: b = {1'b0, cp[6:0]};
        UTT_LEN_TWO: begin
          if (idx == 2'd0) b = {3'b110, cp[10:6]};
          else             b = {2'b10, cp[5:0]};
        end
        UTT_LEN_THREE: begin
          unique case (idx)
            2'd0:    b = {4'b1110, cp[15:12]};
            2'd1:    b = {2'b10, cp[11:6]};
            default: b = {2'b10, cp[5:0]};
          endcase
        end
        UTT_LEN_FOUR: begin
          unique case (idx)
            2'd0:    b = {5'b11110, cp[20:18]};
            2'd1:    b = {2'b10, cp[17:12]};
            2'd2:    b = {2'b10, cp[11:6]};
            default: b = {2'b10, cp[5:0]};
          endcase
        end
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

// ===== rtl/core/utt_front.sv =====
`timescale 1ns / 1ps
module utt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_is_last,
  output logic              push_valid,
  input  logic              push_ready,
  output utt_pkg::utt_job_t push_job
);
  import utt_pkg::*;

  logic       byte_order_r;
  logic [7:0] first_byte_r, first_byte_nxt;
  logic       phase_r, phase_nxt;
  logic       pending_r, pending_nxt;
  logic [9:0] high_r, high_nxt;

  logic [15:0] word;
  logic        is_high, is_low, accept, job_vld;
  logic [20:0] supp_cp;
  utt_job_t    job;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  assign word    = byte_order_r ? {in_byte, first_byte_r} : {first_byte_r, in_byte};
  assign is_high = (word[15:10] == UTT_SURR_HIGH);
  assign is_low  = (word[15:10] == UTT_SURR_LOW);
  assign supp_cp = {1'b0, high_r, word[9:0]} + UTT_SUPP_OFFSET;

  always_comb begin
    job            = '0;
    job.last       = in_is_last;
    first_byte_nxt = first_byte_r;
    phase_nxt      = phase_r;
    pending_nxt    = pending_r;
    high_nxt       = high_r;
    if (!phase_r) begin
      first_byte_nxt = in_byte;
      phase_nxt      = 1'b1;
      // keep the held high surrogate unless the stream ends here
      if (pending_r && in_is_last) begin
        job.cp_a  = {5'd0, UTT_REPL_CHAR};
        job.len_a = UTT_LEN_THREE;
      end
    end else begin
      phase_nxt = 1'b0;
      if (pending_r && is_low) begin
        job.cp_a    = supp_cp;
        job.len_a   = UTT_LEN_FOUR;
        pending_nxt = 1'b0;
      end else if (pending_r) begin
        job.cp_a  = {5'd0, UTT_REPL_CHAR};
        job.len_a = UTT_LEN_THREE;
        if (is_high) begin
          high_nxt = word[9:0];
          if (in_is_last) begin
            job.cp_b  = UTT_REPL_CHAR;
            job.len_b = UTT_LEN_THREE;
          end
        end else begin
          pending_nxt = 1'b0;
          job.cp_b    = word;
          job.len_b   = utt_word_len(word);
        end
      end else if (is_high) begin
        pending_nxt = 1'b1;
        high_nxt    = word[9:0];
        if (in_is_last) begin
          job.cp_a  = {5'd0, UTT_REPL_CHAR};
          job.len_a = UTT_LEN_THREE;
        end
      end else begin
        job.cp_a  = {5'd0, word};
        job.len_a = utt_word_len(word);
      end
    end
    // end of stream: start afresh
    if (in_is_last) begin
      phase_nxt   = 1'b0;
      pending_nxt = 1'b0;
    end
  end

  assign job_vld    = in_is_last || (job.len_a != UTT_LEN_NONE);
  assign push_valid = accept && job_vld;
  assign push_job   = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= 1'b0;
      phase_r      <= 1'b0;
      pending_r    <= 1'b0;
    end else begin
      if (cfg_valid) byte_order_r <= cfg_data;
      if (accept) begin
        phase_r   <= phase_nxt;
        pending_r <= pending_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_byte_r <= first_byte_nxt;
      high_r       <= high_nxt;
    end
  end

endmodule

// ===== rtl/core/utt_queue.sv =====
`timescale 1ns / 1ps
module utt_queue #(
  parameter int DEPTH = utt_pkg::UTT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  utt_pkg::utt_job_t wr_job,
  output logic              rd_valid,
  input  logic              rd_ready,
  output utt_pkg::utt_job_t rd_job
);
  import utt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utt_job_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign wr_ready = (count_r != FULL_CNT);
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_job;
  end

endmodule

// ===== rtl/core/utt_back.sv =====
`timescale 1ns / 1ps
module utt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  utt_pkg::utt_job_t job_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic              out_last
);
  import utt_pkg::*;

  utt_job_t    job_r;
  logic        active_r, sel_r;
  logic [1:0]  idx_r;
  logic        out_valid_r, out_bv_r, out_last_r;
  logic [7:0]  out_byte_r;

  logic [20:0] cur_cp;
  logic [2:0]  cur_len;
  logic        emit, cp_final, job_done, load;

  assign cur_cp   = sel_r ? {5'd0, job_r.cp_b} : job_r.cp_a;
  assign cur_len  = sel_r ? job_r.len_b : job_r.len_a;
  assign emit     = active_r && (!out_valid_r || out_ready);
  assign cp_final = (cur_len == UTT_LEN_NONE) || (({1'b0, idx_r} + 3'd1) == cur_len);
  assign job_done = emit && cp_final && (sel_r || job_r.len_b == UTT_LEN_NONE);
  assign job_ready = !active_r || job_done;
  assign load      = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (load)          active_r <= 1'b1;
      else if (job_done) active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= utt_enc_byte(cur_cp, cur_len, idx_r);
      out_bv_r   <= (job_r.len_a != UTT_LEN_NONE);
      out_last_r <= job_r.last && job_done;
    end
    // a new job may load in the cycle the previous one finishes
    if (load) begin
      job_r <= job_in;
      sel_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (emit) begin
      if (cp_final) begin
        sel_r <= 1'b1;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_last       = out_last_r;

endmodule

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
`timescale 1ns / 1ps
// UTF-16 to UTF-8 transcoder.
// Input channel (in_valid/in_ready): one UTF-16 byte per word, in_is_last on the
// final byte of a stream. Output channel (out_valid/out_ready): one UTF-8 byte per
// word; out_byte_valid low marks an empty end marker, out_last flags the final
// word of the stream. cfg_valid/cfg_data sets the byte order (0 big-endian,
// 1 little-endian); cfg_ready is always high; write only while the block is idle.
// The front pairs bytes, tracks surrogates and queues jobs of up to two code
// points; the back serialises each job into bytes through an output register.
// The path from an accepted input word to its first output byte runs through the
// job queue, the job register of the back and the output register. The back sends
// one byte per cycle while it has jobs and the receiver takes them; an input word
// yields 0 to 6 output words (at most 1.5 per input byte on average for BMP text);
// the front takes a word every cycle while the job queue has room.
// Reset clears the stream state, the job queue and the byte order (big-endian).
// When the receiver stalls the output register holds, the back stops, the queue
// fills and in_ready drops once it is full.
module utf16_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = utt_pkg::UTT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last
);
  import utt_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  utt_job_t push_job, pop_job;

  assign cfg_ready = 1'b1;

  utt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_job   (push_job),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_job   (pop_job)
  );

  utt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (pop_valid),
    .job_ready      (pop_ready),
    .job_in         (pop_job),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } utf8_byte_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  localparam logic [20:0] REPL_CP   = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE = 21'h010000;
  localparam logic [5:0]  HIGH_TAG  = 6'b110110;
  localparam logic [5:0]  LOW_TAG   = 6'b110111;
  localparam int          DRAIN_CYCLES = 12;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last;

  // transcoder copy: byte order, half word, held surrogate
  logic       order_le = 1'b0;
  logic [7:0] held_byte = 8'h00;
  logic       word_half = 1'b0;
  logic       high_held = 1'b0;
  logic [9:0] high_bits = 10'd0;

  utf8_byte_t utf8_expected[$];
  utf8_byte_t head_byte;
  int         fail_count = 0;
  int         bytes_sent = 0;
  int         burst_left = 0;
  rx_mode_e   rx_mode = RX_OPEN;
  logic [7:0] rx_tick = 8'd0;

  utf16_to_utf8_transcoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic push_utf8(input logic [7:0] b);
    utf8_expected.push_back('{b, 1'b1, 1'b0});
  endtask

  task automatic emit_code(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_utf8({1'b0, cp[6:0]});
    end else if (cp <= 21'h7FF) begin
      push_utf8({3'b110, cp[10:6]});
      push_utf8({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      push_utf8({4'b1110, cp[15:12]});
      push_utf8({2'b10, cp[11:6]});
      push_utf8({2'b10, cp[5:0]});
    end else begin
      push_utf8({5'b11110, cp[20:18]});
      push_utf8({2'b10, cp[17:12]});
      push_utf8({2'b10, cp[11:6]});
      push_utf8({2'b10, cp[5:0]});
    end
  endtask

  task automatic transcode_byte(input logic [7:0] b, input logic last);
    logic [15:0] word;
    logic        fresh;
    int          start_count;
    utf8_byte_t  tail;
    start_count = utf8_expected.size();
    if (!word_half) begin
      held_byte = b;
      word_half = 1'b1;
    end else begin
      word = order_le ? {b, held_byte} : {held_byte, b};
      word_half = 1'b0;
      fresh = 1'b1;
      if (high_held) begin
        high_held = 1'b0;
        if (word[15:10] == LOW_TAG) begin
          emit_code({high_bits, word[9:0]} + SUPP_BASE);
          fresh = 1'b0;
        end else begin
          emit_code(REPL_CP);
        end
      end
      if (fresh) begin
        if (word[15:10] == HIGH_TAG) begin
          high_held = 1'b1;
          high_bits = word[9:0];
        end else begin
          emit_code({5'd0, word});
        end
      end
    end
    if (last) begin
      if (high_held) emit_code(REPL_CP);
      // nothing sent for this stream end: expect the empty marker
      if (utf8_expected.size() == start_count) begin
        utf8_expected.push_back('{8'h00, 1'b0, 1'b1});
      end else begin
        tail = utf8_expected.pop_back();
        tail.last = 1'b1;
        utf8_expected.push_back(tail);
      end
      held_byte = 8'h00;
      word_half = 1'b0;
      high_held = 1'b0;
      high_bits = 10'd0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    transcode_byte(b, last);
  endtask

  task automatic send_word(input logic [15:0] w, input logic last);
    if (order_le) begin
      send_byte(w[7:0], 1'b0);
      send_byte(w[15:8], last);
    end else begin
      send_byte(w[15:8], 1'b0);
      send_byte(w[7:0], last);
    end
  endtask

  // hold the sender until every expected word is out, then let the back settle
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_byte_order(input logic le);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= le;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_le = le;
  endtask

  task automatic test_bmp_words();
    send_word(16'h007F, 1'b0);
    send_word(16'h0080, 1'b0);
    send_word(16'h0800, 1'b0);
    send_word(16'hFFFF, 1'b1);
  endtask

  task automatic test_surrogates();
    send_word(16'hDBFF, 1'b0);
    send_word(16'hDFFF, 1'b0);
    // high surrogate followed by a plain word
    send_word(16'hD83D, 1'b0);
    send_word(16'h0041, 1'b0);
    send_word(16'hDC00, 1'b0);
    // dangling high surrogate at the end
    send_word(16'hD800, 1'b1);
  endtask

  task automatic test_stream_ends();
    send_byte(8'h41, 1'b1);
    send_word(16'hD800, 1'b0);
    send_byte(8'h12, 1'b1);
  endtask

  task automatic test_little_endian();
    set_byte_order(1'b1);
    send_word(16'hD83D, 1'b0);
    send_word(16'hDE00, 1'b0);
    send_byte(8'h00, 1'b1);
    set_byte_order(1'b0);
  endtask

  task automatic test_random_streams();
    int          target;
    int          units;
    int          kind;
    logic        odd_tail;
    logic        fin;
    logic [19:0] v;
    logic [15:0] w;
    target = bytes_sent + 140;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 3) == 0) set_byte_order(1'($urandom_range(0, 1)));
      units = $urandom_range(1, 8);
      odd_tail = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < units; k++) begin
        fin = (k == units - 1) && !odd_tail;
        kind = $urandom_range(0, 11);
        v = 20'($urandom_range(0, 20'hFFFFF));
        case (kind)
          0, 1, 2: send_word(16'($urandom_range(0, 16'h007F)), fin);
          3, 4:    send_word(16'($urandom_range(16'h0080, 16'h07FF)), fin);
          5, 6: begin
            w = 16'($urandom_range(16'h0800, 16'hFFFF));
            if (w[15:11] == 5'b11011) w = w ^ 16'h4000;
            send_word(w, fin);
          end
          7, 8, 9: begin
            send_word({HIGH_TAG, v[19:10]}, 1'b0);
            send_word({LOW_TAG, v[9:0]}, fin);
          end
          10: send_word(16'($urandom_range(0, 16'hFFFF)), fin);
          default: begin
            case ($urandom_range(0, 2))
              0:       send_word({HIGH_TAG, v[9:0]}, fin);
              1:       send_word({LOW_TAG, v[9:0]}, fin);
              default: send_byte(8'($urandom_range(0, 255)), fin);
            endcase
          end
        endcase
        if (k == units / 2 && $urandom_range(0, 9) == 0) wait_for_drain();
      end
      if (odd_tail) send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[5:0] == 6'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (rx_tick[1:0] == 2'd0);
      default:   out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (utf8_expected.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected word: byte %h valid %b last %b",
                   out_byte, out_byte_valid, out_last);
        fail_count++;
      end else begin
        head_byte = utf8_expected.pop_front();
        if (out_byte !== head_byte.data || out_byte_valid !== head_byte.present ||
            out_last !== head_byte.last) begin
          if (fail_count < 10)
            $display("mismatch: expected byte %h valid %b last %b, got %h %b %b",
                     head_byte.data, head_byte.present, head_byte.last,
                     out_byte, out_byte_valid, out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_bmp_words();
    test_surrogates();
    test_stream_ends();
    test_little_endian();
    test_random_streams();
    wait_for_drain();
    if (fail_count == 0 && utf8_expected.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
